@@ sv/sci_pkg.sv @@
// shared constants and helpers for the segment/circle crossing pipeline
package sci_pkg;

  // bits of the multiplier operand consumed per pipeline stage
  localparam int MUL_CHUNK = 16;

  // cycles from operands to registered product in sci_mul
  function automatic int mul_lat(input int bw);
    return (bw + MUL_CHUNK - 1) / MUL_CHUNK + 2;
  endfunction

endpackage

@@ sv/sci_dly.sv @@
// fixed-length delay line with a shared advance enable
module sci_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [N];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < N; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[N-1];

endmodule

@@ sv/sci_mul.sv @@
// pipelined signed multiplier, one operand chunk of partial products per stage
module sci_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);
  import sci_pkg::*;

  localparam int CH = MUL_CHUNK;
  localparam int NC = (BW + CH - 1) / CH;
  localparam int BP = NC * CH;
  localparam int PW = AW + BW;

  logic [AW-1:0]    am   [NC];
  logic [BP-1:0]    bm   [NC];
  logic [PW-1:0]    acc  [NC];
  logic             sg   [NC+1];
  logic [AW+CH-1:0] part [NC];
  logic [AW-1:0]    amag;
  logic [BW-1:0]    bmag;

  assign amag = a[AW-1] ? ~a + 1'b1 : a;
  assign bmag = b[BW-1] ? ~b + 1'b1 : b;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      part[k] = {{CH{1'b0}}, am[k]} * {{AW{1'b0}}, bm[k][k*CH +: CH]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am[0]  <= amag;
      bm[0]  <= BP'(bmag);
      sg[0]  <= a[AW-1] ^ b[BW-1];
      acc[0] <= PW'(part[0]);
      for (int k = 1; k < NC; k++) begin
        am[k]  <= am[k-1];
        bm[k]  <= bm[k-1];
        acc[k] <= acc[k-1] + (PW'(part[k]) << (k*CH));
      end
      for (int k = 1; k <= NC; k++) begin
        sg[k] <= sg[k-1];
      end
      p <= sg[NC] ? ~acc[NC-1] + 1'b1 : acc[NC-1];
    end
  end

endmodule

@@ sv/sci_sqrt.sv @@
// pipelined integer square root, one root bit per stage
module sci_sqrt #(
  parameter int IW = 8,
  parameter int RW = (IW + 1) / 2
) (
  input  logic          clk,
  input  logic          en,
  input  logic [IW-1:0] rad,
  output logic [RW-1:0] root
);

  localparam int EW = IW + 2;

  logic [EW-1:0] rem   [RW];
  logic [RW-1:0] rt    [RW];
  logic [EW-1:0] rin   [RW];
  logic [RW-1:0] qin   [RW];
  logic [EW-1:0] trial [RW];
  logic          ge    [RW];

  always_comb begin
    rin[0] = EW'(rad);
    qin[0] = '0;
    for (int k = 1; k < RW; k++) begin
      rin[k] = rem[k-1];
      qin[k] = rt[k-1];
    end
    // (q + 2^i)^2 - q^2 = q*2^(i+1) + 2^(2i)
    for (int k = 0; k < RW; k++) begin
      trial[k] = (EW'(qin[k]) << (RW - k)) | (EW'(1) << (2 * (RW - 1 - k)));
      ge[k]    = rin[k] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RW; k++) begin
        rem[k] <= ge[k] ? rin[k] - trial[k] : rin[k];
        rt[k]  <= qin[k] | (RW'(ge[k]) << (RW - 1 - k));
      end
    end
  end

  assign root = rt[RW-1];

endmodule

@@ sv/sci_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module sci_div #(
  parameter int NW = 16,
  parameter int DW = 8,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          rem_nz
);

  localparam int EW = (NW > DW + QW) ? NW : DW + QW;

  logic [EW-1:0] rem [QW];
  logic [QW-1:0] qt  [QW];
  logic [DW-1:0] dv  [QW];
  logic [EW-1:0] rin [QW];
  logic [QW-1:0] qin [QW];
  logic [DW-1:0] din [QW];
  logic [EW-1:0] sub [QW];
  logic          ge  [QW];

  always_comb begin
    rin[0] = EW'(num);
    qin[0] = '0;
    din[0] = den;
    for (int k = 1; k < QW; k++) begin
      rin[k] = rem[k-1];
      qin[k] = qt[k-1];
      din[k] = dv[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      sub[k] = EW'(din[k]) << (QW - 1 - k);
      ge[k]  = rin[k] >= sub[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem[k] <= ge[k] ? rin[k] - sub[k] : rin[k];
        qt[k]  <= qin[k] | (QW'(ge[k]) << (QW - 1 - k));
        dv[k]  <= din[k];
      end
    end
  end

  assign quo    = qt[QW-1];
  assign rem_nz = |rem[QW-1];

endmodule

@@ sv/segment_circle_intersect_top.sv @@
// segment / circle crossing: top level pipeline
// Finds where a segment crosses a circle centred at the origin and reports the
// crossing nearest the segment start (flag, point, fraction 0..1 along the
// segment). One item enters per clock while the output is not stalled; the
// square root of the discriminant (one root bit per stage) and the three
// dividers (one quotient bit per stage) make up most of the pipeline. A stall
// on the output freezes the whole pipeline.
module segment_circle_intersect_top #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int IN_W  = ((5 * COORD_WIDTH - 1 + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_WIDTH + FRAC_BITS + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // start_x, start_y, end_x, end_y, circle_radius
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // hit_found, hit_x, hit_y, hit_fraction
  output logic [OUT_W-1:0] m_tdata
);
  import sci_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int W1  = CW + 1;
  localparam int P1W = 2 * W1;
  localparam int W2  = P1W + 1;
  localparam int P2W = 2 * W2;
  localparam int RW  = (P2W + 1) / 2;
  localparam int NSW = W2 + 2;
  localparam int P3W = W2 + W1 + 2;
  localparam int QW  = (W1 > FRAC_BITS + 1) ? W1 : FRAC_BITS + 1;
  localparam int FNW = W2 + FRAC_BITS;
  localparam int DNW = (P3W > FNW) ? P3W : FNW;
  localparam int SW  = ((QW > CW) ? QW : CW) + 3;
  localparam int LA  = mul_lat(W1);
  localparam int LB  = mul_lat(W2);
  localparam int LC  = mul_lat(W1 + 1);
  localparam int LT  = LA + LB + RW + LC + QW + 5;

  logic en;
  logic [LT-1:0] vld;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LT-2:0], s_tvalid};
    end
  end

  // input register and differences
  logic signed [CW-1:0] x1, y1, x2, y2;
  logic [CW-2:0]        rad;
  logic signed [W1-1:0] dx, dy;
  logic signed [CW-1:0] ix1, iy1, ix2, iy2;

  assign ix1 = s_tdata[0 +: CW];
  assign iy1 = s_tdata[CW +: CW];
  assign ix2 = s_tdata[2*CW +: CW];
  assign iy2 = s_tdata[3*CW +: CW];

  always_ff @(posedge clk) begin
    if (en) begin
      x1  <= ix1;
      y1  <= iy1;
      x2  <= ix2;
      y2  <= iy2;
      rad <= s_tdata[4*CW +: CW-1];
      dx  <= {ix2[CW-1], ix2} - {ix1[CW-1], ix1};
      dy  <= {iy2[CW-1], iy2} - {iy1[CW-1], iy1};
    end
  end

  logic signed [W1-1:0] x1e, y1e, x2e, y2e, rade;
  assign x1e  = {x1[CW-1], x1};
  assign y1e  = {y1[CW-1], y1};
  assign x2e  = {x2[CW-1], x2};
  assign y2e  = {y2[CW-1], y2};
  assign rade = {2'b00, rad};

  logic signed [P1W-1:0] pdxx, pdyy, pxdx, pydy, pxy, pyx, prr;

  sci_mul #(.AW(W1), .BW(W1)) u_mul_dxx (.clk, .en, .a(dx),   .b(dx),   .p(pdxx));
  sci_mul #(.AW(W1), .BW(W1)) u_mul_dyy (.clk, .en, .a(dy),   .b(dy),   .p(pdyy));
  sci_mul #(.AW(W1), .BW(W1)) u_mul_xdx (.clk, .en, .a(x1e),  .b(dx),   .p(pxdx));
  sci_mul #(.AW(W1), .BW(W1)) u_mul_ydy (.clk, .en, .a(y1e),  .b(dy),   .p(pydy));
  sci_mul #(.AW(W1), .BW(W1)) u_mul_xy  (.clk, .en, .a(x1e),  .b(y2e),  .p(pxy));
  sci_mul #(.AW(W1), .BW(W1)) u_mul_yx  (.clk, .en, .a(x2e),  .b(y1e),  .p(pyx));
  sci_mul #(.AW(W1), .BW(W1)) u_mul_rr  (.clk, .en, .a(rade), .b(rade), .p(prr));

  // a = |d|^2, b = S.d, cross = S x d, r^2
  logic signed [W2-1:0] a3, b3, d3, rr3;

  always_ff @(posedge clk) begin
    if (en) begin
      a3  <= {pdxx[P1W-1], pdxx} + {pdyy[P1W-1], pdyy};
      b3  <= {pxdx[P1W-1], pxdx} + {pydy[P1W-1], pydy};
      d3  <= {pxy[P1W-1], pxy} - {pyx[P1W-1], pyx};
      rr3 <= {prr[P1W-1], prr};
    end
  end

  logic signed [P2W-1:0] dsq, ra;

  sci_mul #(.AW(W2), .BW(W2)) u_mul_dsq (.clk, .en, .a(d3),  .b(d3), .p(dsq));
  sci_mul #(.AW(W2), .BW(W2)) u_mul_ra  (.clk, .en, .a(rr3), .b(a3), .p(ra));

  // discriminant
  logic           pos5;
  logic [P2W-1:0] delta5;

  always_ff @(posedge clk) begin
    if (en) begin
      pos5   <= ra > dsq;
      delta5 <= ra - dsq;
    end
  end

  logic [RW-1:0] sq;
  sci_sqrt #(.IW(P2W), .RW(RW)) u_sqrt (.clk, .en, .rad(delta5), .root(sq));

  logic          pos7d;
  logic [W2-1:0] a7, b7;

  sci_dly #(.W(1), .N(RW)) u_dly_pos (.clk, .en, .d(pos5), .q(pos7d));
  sci_dly #(.W(2*W2), .N(LB+RW+1)) u_dly_ab (
    .clk, .en, .d({a3, b3}), .q({a7, b7})
  );

  // pick the nearer root that lies on the segment
  logic signed [NSW-1:0] nbx, sxx, n1, n2, ax;
  logic                  r1, r2;

  always_comb begin
    nbx = -{{2{b7[W2-1]}}, b7};
    sxx = NSW'(sq);
    ax  = NSW'(a7);
    n1  = nbx - sxx;
    n2  = nbx + sxx;
    r1  = !n1[NSW-1] && (n1 <= ax);
    r2  = !n2[NSW-1] && (n2 <= ax);
  end

  logic [W2-1:0] pk7, a7r;
  logic          hit7;

  always_ff @(posedge clk) begin
    if (en) begin
      pk7  <= r1 ? W2'(n1) : W2'(n2);
      hit7 <= pos7d && (r1 || r2);
      a7r  <= a7;
    end
  end

  logic [W1-1:0] dxm, dym, dxm7, dym7;
  assign dxm = dx[W1-1] ? ~dx + 1'b1 : dx;
  assign dym = dy[W1-1] ? ~dy + 1'b1 : dy;

  sci_dly #(.W(2*W1), .N(LA+LB+RW+3)) u_dly_dm (
    .clk, .en, .d({dxm, dym}), .q({dxm7, dym7})
  );

  logic signed [P3W-1:0] pnx, pny;
  logic signed [W2:0]    pke;
  logic signed [W1:0]    dxe, dye;
  assign pke = {1'b0, pk7};
  assign dxe = {1'b0, dxm7};
  assign dye = {1'b0, dym7};

  sci_mul #(.AW(W2+1), .BW(W1+1)) u_mul_nx (.clk, .en, .a(pke), .b(dxe), .p(pnx));
  sci_mul #(.AW(W2+1), .BW(W1+1)) u_mul_ny (.clk, .en, .a(pke), .b(dye), .p(pny));

  logic [FNW-1:0] fnd;
  logic [W2-1:0]  ad;

  sci_dly #(.W(FNW+W2), .N(LC)) u_dly_fa (
    .clk, .en, .d({pk7, {FRAC_BITS{1'b0}}, a7r}), .q({fnd, ad})
  );

  logic [QW-1:0] qx, qy, qf;
  logic          nzx, nzy;

  sci_div #(.NW(DNW), .DW(W2), .QW(QW)) u_div_x (
    .clk, .en, .num(DNW'($unsigned(pnx))), .den(ad), .quo(qx), .rem_nz(nzx)
  );
  sci_div #(.NW(DNW), .DW(W2), .QW(QW)) u_div_y (
    .clk, .en, .num(DNW'($unsigned(pny))), .den(ad), .quo(qy), .rem_nz(nzy)
  );
  sci_div #(.NW(DNW), .DW(W2), .QW(QW)) u_div_f (
    .clk, .en, .num(DNW'(fnd)), .den(ad), .quo(qf), .rem_nz()
  );

  logic          hitd;
  logic [CW-1:0] x1d_u, y1d_u;
  logic          sdx, sdy;

  sci_dly #(.W(1), .N(LC+QW)) u_dly_hit (.clk, .en, .d(hit7), .q(hitd));
  sci_dly #(.W(2*CW+2), .N(LT-2)) u_dly_xy (
    .clk, .en, .d({x1, y1, dx[W1-1], dy[W1-1]}), .q({x1d_u, y1d_u, sdx, sdy})
  );

  function automatic logic [CW-1:0] sat(input logic [SW-1:0] v);
    logic [SW-CW:0] top;
    top = v[SW-1:CW-1];
    if (&top || ~|top) begin
      return v[CW-1:0];
    end else begin
      return v[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  // floor toward minus infinity when the step is negative
  logic signed [CW-1:0] x1d, y1d;
  logic signed [QW+1:0] tx, ty, vx, vy;
  logic signed [SW-1:0] sumx, sumy;

  always_comb begin
    x1d  = x1d_u;
    y1d  = y1d_u;
    tx   = {2'b00, qx} + (QW+2)'(nzx);
    ty   = {2'b00, qy} + (QW+2)'(nzy);
    vx   = sdx ? -tx : {2'b00, qx};
    vy   = sdy ? -ty : {2'b00, qy};
    sumx = SW'(x1d) + SW'(vx);
    sumy = SW'(y1d) + SW'(vy);
  end

  logic                 o_hit;
  logic [CW-1:0]        o_x, o_y;
  logic [FRAC_BITS:0]   o_frac;

  always_ff @(posedge clk) begin
    if (en) begin
      o_hit  <= hitd;
      o_x    <= hitd ? sat(sumx) : '0;
      o_y    <= hitd ? sat(sumy) : '0;
      o_frac <= hitd ? qf[FRAC_BITS:0] : '0;
    end
  end

  assign m_tdata = OUT_W'({o_frac, o_y, o_x, o_hit});

  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !o_hit |-> o_x == '0 && o_y == '0 && o_frac == '0)
    else $error("miss item carries nonzero payload");

  a_frac_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_hit |-> o_frac <= {1'b1, {FRAC_BITS{1'b0}}})
    else $error("hit fraction above one");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted item lost at pipeline entry");

endmodule

@@ bench/segment_circle_intersect_checker.sv @@
// checker for the segment/circle crossing pipeline: predicts each result and compares
`timescale 1ns / 100ps

module segment_circle_intersect_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [159:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [87:0]  m_tdata,
  output int           fail_count,
  output int           pending_hits,
  output int           hit_count,
  output int           result_count
);

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic        found;
    logic [31:0] x;
    logic [31:0] y;
    logic [16:0] frac;
  } crossing_t;

  crossing_t crossing_q[$];

  function automatic wide_t sext32(input logic [31:0] v);
    return {{224{v[31]}}, v};
  endfunction

  // floor(num / den) toward minus infinity, den > 0
  function automatic wide_t floor_div(input wide_t num, input wide_t den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic logic [31:0] clamp32(input wide_t v);
    if (v > 256'sd2147483647) return 32'h7fffffff;
    if (v < -256'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic crossing_t nearest_crossing(input logic [159:0] d);
    wide_t x1, y1, dx, dy, r, a, b, cr, delta, root, cand, n1, n2, n;
    crossing_t res;
    res = '0;
    x1 = sext32(d[31:0]);
    y1 = sext32(d[63:32]);
    dx = sext32(d[95:64]) - x1;
    dy = sext32(d[127:96]) - y1;
    r  = {225'b0, d[158:128]};
    a  = dx * dx + dy * dy;
    b  = x1 * dx + y1 * dy;
    cr = x1 * dy - y1 * dx;
    delta = r * r * a - cr * cr;
    if (delta <= 0) return res;
    root = 0;
    for (int i = 80; i >= 0; i--) begin
      cand = root | (wide_t'(1) << i);
      if (cand * cand <= delta) root = cand;
    end
    n1 = -b - root;
    n2 = -b + root;
    if (n1 >= 0 && n1 <= a) n = n1;
    else if (n2 >= 0 && n2 <= a) n = n2;
    else return res;
    res.found = 1'b1;
    res.frac  = 17'((n <<< 16) / a);
    res.x     = clamp32(x1 + floor_div(n * dx, a));
    res.y     = clamp32(y1 + floor_div(n * dy, a));
    return res;
  endfunction

  assign pending_hits = crossing_q.size();

  always @(posedge clk) begin
    crossing_t got, want;
    if (rst) begin
      crossing_q.delete();
      fail_count   <= 0;
      hit_count    <= 0;
      result_count <= 0;
    end else begin
      if (s_tvalid && s_tready) crossing_q = {crossing_q, nearest_crossing(s_tdata)};
      if (m_tvalid && m_tready) begin
        got = {m_tdata[0], m_tdata[32:1], m_tdata[64:33], m_tdata[81:65]};
        result_count <= result_count + 1;
        if (crossing_q.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_count <= fail_count + 1;
        end else begin
          want = crossing_q.pop_front();
          if (want.found) hit_count <= hit_count + 1;
          if (got.found !== want.found) begin
            $error("hit_found expected %0d actual %0d", want.found, got.found);
            fail_count <= fail_count + 1;
          end else if (got.x !== want.x) begin
            $error("hit_x expected %h actual %h", want.x, got.x);
            fail_count <= fail_count + 1;
          end else if (got.y !== want.y) begin
            $error("hit_y expected %h actual %h", want.y, got.y);
            fail_count <= fail_count + 1;
          end else if (got.frac !== want.frac) begin
            $error("hit_fraction expected %h actual %h", want.frac, got.frac);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ bench/segment_circle_intersect_top_test.sv @@
// testbench top for the segment/circle crossing pipeline: stimulus and verdict
`timescale 1ns / 100ps

module segment_circle_intersect_top_test;

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam int RAND_ITEMS   = 1200;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [159:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [87:0]  m_tdata;
  int           fail_count, pending_hits, hit_count, result_count;
  int           send_idle_pct, recv_idle_pct;
  int           items_sent;
  bit           holdoff_done;

  segment_circle_intersect_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  segment_circle_intersect_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending_hits(pending_hits),
    .hit_count(hit_count), .result_count(result_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400us;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

  // receiver: random stalls plus one long hold-off while the sender keeps going
  initial begin
    m_tready = 1'b0;
    holdoff_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!holdoff_done && items_sent >= 300) begin
        holdoff_done = 1'b1;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [159:0] segment_item(input logic [31:0] sx, input logic [31:0] sy,
                                                input logic [31:0] ex, input logic [31:0] ey,
                                                input logic [31:0] rad);
    return {rad, ey, ex, sy, sx};
  endfunction

  task automatic send_item(input logic [159:0] d);
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // mostly segments near a circle of modest size so crossings are common
  task automatic send_random;
    logic [31:0] rad, span;
    logic [31:0] c[4];
    if ($urandom_range(9) < 2) begin
      send_item({$urandom, $urandom, $urandom, $urandom, $urandom});
    end else begin
      rad  = $urandom_range(32'h0000_0100, 32'h0200_0000);
      span = rad * ($urandom_range(1, 3));
      foreach (c[i]) c[i] = $urandom_range(0, 2 * span) - span;
      if ($urandom_range(9) == 0) c[2] = c[0];
      if ($urandom_range(9) == 0) c[3] = c[1];
      send_item(segment_item(c[0], c[1], c[2], c[3], {1'($urandom_range(1)), rad[30:0]}));
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    items_sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // crossing through the circle along x, nearer root first
    send_item(segment_item(-2 * ONE, 0, 2 * ONE, 0, ONE));
    // vertical segment
    send_item(segment_item(ONE / 2, -3 * ONE, ONE / 2, 3 * ONE, ONE));
    // degenerate segment on the circle
    send_item(segment_item(ONE, 0, ONE, 0, ONE));
    // tangent line
    send_item(segment_item(-2 * ONE, ONE, 2 * ONE, ONE, ONE));
    // clear miss
    send_item(segment_item(-2 * ONE, 5 * ONE, 2 * ONE, 5 * ONE, ONE));
    // wholly inside
    send_item(segment_item(-ONE / 4, 0, ONE / 4, 0, ONE));
    // wholly outside on the line, both ends beyond
    send_item(segment_item(3 * ONE, 0, 5 * ONE, 0, ONE));
    // start inside, leaves the circle: far root only
    send_item(segment_item(0, 0, 3 * ONE, 3 * ONE, 2 * ONE));
    // ends exactly on the circle
    send_item(segment_item(0, 0, ONE, 0, ONE));
    send_item(segment_item(ONE, 0, 2 * ONE, 0, ONE));
    // radius zero
    send_item(segment_item(-ONE, 0, ONE, 0, 0));
    // coordinate extremes and largest radius
    send_item(segment_item(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                           32'h7fff_ffff));
    send_item(segment_item(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                           32'h7fff_ffff));
    send_item(segment_item(32'h8000_0000, 0, 32'h7fff_ffff, 0, 32'h4000_0000));
    send_item(segment_item(0, 32'h7fff_ffff, 0, 32'h8000_0000, 32'h7fff_ffff));
    send_item(segment_item(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0001, 1));
    // radius top bit beyond field width must be ignored
    send_item(segment_item(-2 * ONE, 0, 2 * ONE, 0, 32'h8001_0000));
    send_item(segment_item('1, '1, '1, '1, '1));

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 54 : 0;
      recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 16 : 0;
      for (int i = 0; i < RAND_ITEMS / 3; i++) send_random();
    end
    s_tvalid <= 1'b0;
    recv_idle_pct = 0;

    while (pending_hits != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("sent %0d segments, %0d results checked, %0d with a crossing",
             items_sent, result_count, hit_count);
    $display("stalls on both sides and one long output hold-off were applied");
    if (fail_count == 0 && pending_hits == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
